[sv/faes_pkg.sv]
package faes_pkg;

  // Channel order: temperature A, temperature B, level A, level B
  localparam int NCH       = 4;
  localparam int CH_W      = 2;
  localparam int NLVL      = 2;

  // Averaging window, a power of two
  localparam int WIN_LOG2  = 4;
  localparam int WINDOW    = 1 << WIN_LOG2;
  localparam int SLOT_W    = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;

  localparam int SAMPLE_W  = 10;
  localparam int SUM_W     = SAMPLE_W + WIN_LOG2;
  localparam int FRAC_W    = 16;
  localparam int SMOOTH_W  = SAMPLE_W + FRAC_W;
  localparam int ALPHA_W   = 16;
  localparam int BETA_W    = ALPHA_W + 1;
  localparam int PROD_W    = SMOOTH_W + BETA_W;
  localparam int ROW_W     = NCH * SAMPLE_W;
  localparam int CHAN_W    = SUM_W + SMOOTH_W;

  localparam logic [BETA_W-1:0] ONE_Q16 = BETA_W'(1 << FRAC_W);

  // Temperature scaling: smooth * 500 / (1023 << 16)
  localparam int TEMP_W     = 9;
  localparam int TEMP_SPAN  = 500;
  localparam int SPAN_W     = 9;
  localparam int TPROD_W    = SMOOTH_W + SPAN_W;
  localparam int TX_W       = TPROD_W - FRAC_W;
  localparam int FS_SHIFT   = 10;
  localparam int FULL_SCALE = (1 << FS_SHIFT) - 1;

  // Level percent
  localparam int PCT_W     = 7;
  localparam int PCT_MAX   = 100;
  localparam int NUM_W     = SAMPLE_W + PCT_W;
  localparam int DCNT_W    = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LMAX_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LMAX_B = 2'd2;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST = 16'd5243;
  localparam logic [SAMPLE_W-1:0] LMAX_RST  = 10'd1023;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_WB,
    ST_TMUL,
    ST_TFIX,
    ST_LSTART,
    ST_LWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] percent;
    logic             full;
  } pct_res_t;

endpackage

[sv/faes_pct_div.sv]
module faes_pct_div
  import faes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] whole_i,
  input  logic [SAMPLE_W-1:0] max_i,
  output pct_res_t            res_o
);

  logic              busy_q;
  logic              done_q;
  logic              full_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  dsh_q;
  logic [PCT_W-1:0]  quo_q;
  logic              fits;
  logic              clamp;

  assign fits  = (rem_q >= dsh_q);
  assign clamp = (max_i == '0) || (whole_i >= max_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= !clamp;
        done_q <= clamp;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      full_q <= clamp;
      quo_q  <= PCT_W'(PCT_MAX);
      cnt_q  <= DCNT_W'(PCT_W - 1);
      rem_q  <= NUM_W'(whole_i) * NUM_W'(PCT_MAX);
      dsh_q  <= NUM_W'({max_i, {(PCT_W-1){1'b0}}});
    end else if (busy_q) begin
      quo_q <= {quo_q[PCT_W-2:0], fits};
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign res_o.done    = done_q;
  assign res_o.percent = quo_q;
  assign res_o.full    = full_q;

endmodule

[sv/four_channel_average_ema_scaler.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o    | prime_i, sample_{temp,level}_{a,b}_i
// output   | out_valid_o / out_stall_i  | temp_{a,b}_o, percent_{a,b}_o, full_{a,b}_o
// config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One transaction at a time. A normal one runs, from acceptance, per channel a memory
// read-modify-write and two smoothing multiplies, per temperature a multiply and a
// correction, per level percent a divider start, 7 divider steps and the result (a
// clamp skips the steps), then the output load and a return to idle. Reset clears the
// ring and channel valid bits at once, no pass. A waiting result delays only the output
// load, which waits until the output register is free.
module four_channel_average_ema_scaler
  import faes_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  prime_i,
  input  logic [SAMPLE_W-1:0]   sample_temp_a_i,
  input  logic [SAMPLE_W-1:0]   sample_temp_b_i,
  input  logic [SAMPLE_W-1:0]   sample_level_a_i,
  input  logic [SAMPLE_W-1:0]   sample_level_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TEMP_W-1:0]     temp_a_o,
  output logic [TEMP_W-1:0]     temp_b_o,
  output logic [PCT_W-1:0]      percent_a_o,
  output logic [PCT_W-1:0]      percent_b_o,
  output logic                  full_a_o,
  output logic                  full_b_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration
  logic [ALPHA_W-1:0]  alpha_q;
  logic [SAMPLE_W-1:0] lmax_q [NLVL];

  // Control
  state_e            state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [SLOT_W-1:0] slot_q;
  logic              prime_q;
  logic              in_acc;
  logic              out_free;

  // Memories: sample rings (one row per slot) and per-channel {sum, smooth}
  logic [ROW_W-1:0]  ring_mem [WINDOW];
  logic [WINDOW-1:0] ring_vld_q;
  logic [ROW_W-1:0]  ring_rd_q;
  logic              ring_rvld_q;
  logic [CHAN_W-1:0] chan_mem [NCH];
  logic [NCH-1:0]    chan_vld_q;
  logic [CHAN_W-1:0] chan_rd_q;
  logic              chan_rvld_q;

  logic              ring_re, ring_we;
  logic              chan_re, chan_we;
  logic [CH_W-1:0]   chan_raddr;
  logic [CHAN_W-1:0] chan_wdata;
  logic [ROW_W-1:0]  ring_wdata;

  // Datapath
  logic [SAMPLE_W-1:0] smp_q [NCH];
  logic [SUM_W-1:0]    sum_q;
  logic [SMOOTH_W-1:0] avg_q;
  logic [SMOOTH_W-1:0] sm_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SMOOTH_W-1:0] res_sm_q [NCH];
  logic [TPROD_W-1:0]  tprod_q;
  logic [TEMP_W-1:0]   temp_q [NLVL];
  logic [PCT_W-1:0]    pct_q [NLVL];
  logic                full_q [NLVL];

  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    old_sum;
  logic [SMOOTH_W-1:0] old_sm;
  logic [SUM_W-1:0]    sum_new;
  logic [SMOOTH_W-1:0] sm_new;
  logic [BETA_W-1:0]   beta;
  logic [TX_W-1:0]     tx;
  logic [TEMP_W-1:0]   tq0;
  logic [FS_SHIFT:0]   trem;
  logic [TEMP_W-1:0]   temp_new;

  // Level divider
  logic     div_start;
  pct_res_t div_res;

  // Output register
  logic              out_valid_q;
  logic [TEMP_W-1:0] temp_a_q, temp_b_q;
  logic [PCT_W-1:0]  percent_a_q, percent_b_q;
  logic              full_a_q, full_b_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= ALPHA_RST;
      lmax_q[0] <= LMAX_RST;
      lmax_q[1] <= LMAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA:  alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        CFG_LMAX_A: lmax_q[0] <= cfg_data_i[SAMPLE_W-1:0];
        CFG_LMAX_B: lmax_q[1] <= cfg_data_i[SAMPLE_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and memory strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    chan_re    = 1'b0;
    chan_we    = 1'b0;
    chan_raddr = '0;
    chan_wdata = {sum_q, sm_new};
    div_start  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d    = '0;
          ring_re = !prime_i;
          chan_re = !prime_i;
          state_d = prime_i ? ST_PRIME : ST_SUM;
        end
      end
      ST_PRIME: begin
        // load smooth with the raw sample, sum cleared
        chan_we    = 1'b1;
        chan_wdata = {{SUM_W{1'b0}}, smp_q[ch_q], {FRAC_W{1'b0}}};
        ch_d       = ch_q + 1'b1;
        if (ch_q == CH_W'(NCH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        ring_we = (ch_q == '0);
        state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_WB;
      ST_WB: begin
        chan_we    = 1'b1;
        chan_re    = (ch_q != CH_W'(NCH - 1));
        chan_raddr = ch_q + 1'b1;
        ch_d       = ch_q + 1'b1;
        state_d    = (ch_q == CH_W'(NCH - 1)) ? ST_TMUL : ST_SUM;
      end
      ST_TMUL: state_d = ST_TFIX;
      ST_TFIX: begin
        ch_d    = ch_q + 1'b1;
        state_d = (ch_q[0]) ? ST_LSTART : ST_TMUL;
      end
      ST_LSTART: begin
        div_start = 1'b1;
        state_d   = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (div_res.done) begin
          ch_d    = ch_q + 1'b1;
          state_d = (ch_q[0]) ? ST_DONE : ST_LSTART;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring memory: one row holds the four channels of one slot
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ring_wdata[c*SAMPLE_W +: SAMPLE_W] = smp_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[slot_q];
    end
  end

  // Row valid bits stand in for the cleared ring: a row never written since
  // reset or the last prime reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q  <= '0;
      ring_rvld_q <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (in_acc && prime_i) begin
        ring_vld_q <= '0;
      end else if (ring_we) begin
        ring_vld_q[slot_q] <= 1'b1;
        // advance and wrap the write slot
        slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      end
      if (ring_re) begin
        ring_rvld_q <= ring_vld_q[slot_q];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel memory: running sum and smoothed value per channel
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (chan_we) begin
      chan_mem[ch_q] <= chan_wdata;
    end
    if (chan_re) begin
      chan_rd_q <= chan_mem[chan_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_vld_q  <= '0;
      chan_rvld_q <= 1'b0;
    end else begin
      if (chan_we) begin
        chan_vld_q[ch_q] <= 1'b1;
      end
      if (chan_re) begin
        chan_rvld_q <= chan_vld_q[chan_raddr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Smoothing datapath
  // ---------------------------------------------------------------------------
  assign old_smp = ring_rvld_q ? ring_rd_q[ch_q*SAMPLE_W +: SAMPLE_W] : '0;
  assign old_sum = chan_rvld_q ? chan_rd_q[SMOOTH_W +: SUM_W] : '0;
  assign old_sm  = chan_rvld_q ? chan_rd_q[SMOOTH_W-1:0] : '0;
  // the overwritten sample is part of the sum, so this never underflows
  assign sum_new = old_sum - SUM_W'(old_smp) + SUM_W'(smp_q[ch_q]);
  assign beta    = ONE_Q16 - BETA_W'(alpha_q);
  assign sm_new  = prod_q[FRAC_W +: SMOOTH_W];

  // Temperature: x = smooth*500 >> 16, then x / 1023 as x >> 10 plus one
  // correction step, since x = 1023*(x >> 10) + (x mod 1024 + x >> 10).
  assign tx       = tprod_q[FRAC_W +: TX_W];
  assign tq0      = TEMP_W'(tx >> FS_SHIFT);
  assign trem     = (FS_SHIFT+1)'(tx[FS_SHIFT-1:0]) + (FS_SHIFT+1)'(tq0);
  assign temp_new = tq0 + TEMP_W'(trem >= (FS_SHIFT+1)'(FULL_SCALE));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prime_q  <= prime_i;
      smp_q[0] <= sample_temp_a_i;
      smp_q[1] <= sample_temp_b_i;
      smp_q[2] <= sample_level_a_i;
      smp_q[3] <= sample_level_b_i;
    end
    unique case (state_q)
      ST_SUM: begin
        sum_q <= sum_new;
        avg_q <= SMOOTH_W'({sum_new, {FRAC_W{1'b0}}} >> WIN_LOG2);
        sm_q  <= old_sm;
      end
      ST_MUL1: prod_q <= PROD_W'(alpha_q) * PROD_W'(avg_q);
      ST_MUL2: prod_q <= prod_q + PROD_W'(beta) * PROD_W'(sm_q);
      ST_WB:   res_sm_q[ch_q] <= sm_new;
      ST_TMUL: tprod_q <= TPROD_W'(res_sm_q[ch_q]) * TPROD_W'(TEMP_SPAN);
      ST_TFIX: temp_q[ch_q[0]] <= temp_new;
      ST_LWAIT: begin
        if (div_res.done) begin
          pct_q[ch_q[0]]  <= div_res.percent;
          full_q[ch_q[0]] <= div_res.full;
        end
      end
      default: ;
    endcase
  end

  // Shared divider for both level channels; ch_q selects the channel.
  faes_pct_div u_pct_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .whole_i (res_sm_q[ch_q][FRAC_W +: SAMPLE_W]),
    .max_i   (lmax_q[ch_q[0]]),
    .res_o   (div_res)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free && !prime_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      temp_a_q    <= temp_q[0];
      temp_b_q    <= temp_q[1];
      percent_a_q <= pct_q[0];
      percent_b_q <= pct_q[1];
      full_a_q    <= full_q[0];
      full_b_q    <= full_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_a_o    = temp_a_q;
  assign temp_b_o    = temp_b_q;
  assign percent_a_o = percent_a_q;
  assign percent_b_o = percent_b_q;
  assign full_a_o    = full_a_q;
  assign full_b_o    = full_b_q;

endmodule
